/* hdl/lfo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_pkg
// Shared types, register indexes and constants of the oscillator voice.
// ----------------------------------------------------------------------------
package lfo_pkg;

  // default phase accumulator width
  localparam int PhaseBitsDef = 24;

  // depth of the queue between front and back
  localparam int QueueDepth = 2;

  // fixed-point constants
  localparam logic [24:0]        OneQ24   = 25'd16777216;
  localparam logic signed [17:0] OneQ16   = 18'sd65536;
  localparam logic [31:0]        LfsrSeed = 32'h2545F491;
  localparam logic signed [23:0] ScaleRst = 24'sd65536;
  localparam logic signed [25:0] SatMax   = 26'sd8388607;
  localparam logic signed [25:0] SatMin   = -26'sd8388608;

  // configuration register indexes
  localparam logic [2:0] RegBaseFreq    = 3'd0;
  localparam logic [2:0] RegRateRatio   = 3'd1;
  localparam logic [2:0] RegPhaseOffset = 3'd2;
  localparam logic [2:0] RegWaveSelect  = 3'd3;
  localparam logic [2:0] RegOutScale    = 3'd4;
  localparam logic [2:0] RegOutOffset   = 3'd5;
  localparam logic [2:0] RegDelayFrames = 3'd6;
  localparam logic [2:0] RegFadeStep    = 3'd7;

  // wave select codes
  localparam logic [3:0] WaveTri    = 4'd0;
  localparam logic [3:0] WaveSine   = 4'd1;
  localparam logic [3:0] WavePulse3 = 4'd2;
  localparam logic [3:0] WaveSquare = 4'd3;
  localparam logic [3:0] WavePulse1 = 4'd4;
  localparam logic [3:0] WavePulse8 = 4'd5;
  localparam logic [3:0] WaveRamp   = 4'd6;
  localparam logic [3:0] WaveSaw    = 4'd7;
  localparam logic [3:0] WaveHold   = 4'd8;

  // command codes of an input beat
  localparam logic CmdTick  = 1'b0;
  localparam logic CmdStart = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic signed [23:0] freq_mod;
    logic [22:0]        trigger_delay;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] lfo_value;
    logic               in_delay;
  } out_item_t;

  typedef struct packed {
    logic [23:0]        base_freq;
    logic [31:0]        rate_ratio;
    logic [23:0]        phase_offset;
    logic [3:0]         wave_select;
    logic signed [23:0] out_scale;
    logic signed [23:0] out_offset;
    logic [22:0]        delay_frames;
    logic [23:0]        fade_step;
  } cfg_t;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OpStart,
    OpDelay,
    OpRun
  } op_e;

  typedef struct packed {
    op_e                kind;
    logic signed [23:0] freq_mod;
    logic               delay_flag;
  } op_t;

endpackage

/* hdl/lfo_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_queue
// Short register queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module lfo_queue
  import lfo_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  op_t  wr_op_i,
  output logic full_o,
  input  logic rd_i,
  output op_t  rd_op_o,
  output logic valid_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  op_t             mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign rd_op_o = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        count_q <= count_q + 1'b1;
      end else if (!wr_i && rd_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_op_i;
    end
  end

endmodule

/* hdl/lfo_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_front
// Accepts input beats, runs the start delay count and classifies each beat
// as start, delay tick or running tick.
// ----------------------------------------------------------------------------
module lfo_front
  import lfo_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     push_i,
  input  in_item_t item_i,
  input  logic     q_full_i,
  output logic     full_o,
  output logic     q_wr_o,
  output op_t      q_op_o
);

  logic [23:0] delay_left_q, delay_left_d;
  logic [23:0] new_delay;
  logic        accept;

  assign full_o    = q_full_i;
  assign accept    = push_i && !q_full_i;
  assign q_wr_o    = accept;
  assign new_delay = {1'b0, item_i.trigger_delay} + {1'b0, cfg_i.delay_frames};

  // classify the beat and update the delay count
  always_comb begin
    delay_left_d      = delay_left_q;
    q_op_o.kind       = OpRun;
    q_op_o.freq_mod   = item_i.freq_mod;
    q_op_o.delay_flag = 1'b0;
    if (item_i.cmd == CmdStart) begin
      q_op_o.kind       = OpStart;
      q_op_o.delay_flag = (new_delay != '0);
      if (accept) begin
        delay_left_d = new_delay;
      end
    end else if (delay_left_q != '0) begin
      q_op_o.kind       = OpDelay;
      q_op_o.delay_flag = 1'b1;
      if (accept) begin
        delay_left_d = delay_left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_left_q <= '0;
    end else begin
      delay_left_q <= delay_left_d;
    end
  end

endmodule

/* hdl/lfo_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_back
// Executes queued operations: waveform shaping, gain, fade-in and phase
// advance over one shared registered multiplier, with a one-beat result slot.
// ----------------------------------------------------------------------------
module lfo_back
  import lfo_pkg::*;
#(
  parameter int PHASE_BITS = PhaseBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  op_t       q_op_i,
  output logic      q_rd_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t res_o
);

  localparam int Up = (PHASE_BITS >= 24) ? PHASE_BITS - 24 : 0;
  localparam int Dn = (PHASE_BITS < 24) ? 24 - PHASE_BITS : 0;

  typedef enum logic [3:0] {
    SIdle,
    SSine,
    SShape,
    SScale,
    SOffs,
    SFade,
    SFade2,
    SPhase,
    SEmit
  } state_e;

  state_e                  state_q;
  logic [PHASE_BITS-1:0]   phase_acc_q;
  logic [24:0]             fade_pos_q;
  logic signed [17:0]      hold_value_q;
  logic                    hold_half_q;
  logic [31:0]             lfsr_q;
  logic signed [17:0]      shape_q;
  logic signed [25:0]      val_q;
  logic                    dly_q;
  logic signed [23:0]      fmod_q;
  logic                    res_valid_q;
  out_item_t               res_q;
  logic signed [60:0]      mul_q;

  logic signed [33:0]      mul_a;
  logic signed [26:0]      mul_b;
  logic [55:0]             off_w, ph_w;
  logic [PHASE_BITS-1:0]   off_pb, ph_pb, phase_up;
  logic [23:0]             ph24;
  logic signed [27:0]      ph4, tri_t, ramp_t, saw_t;
  logic signed [25:0]      sine_x, sine_ax, sine_b;
  logic signed [60:0]      sine_neg, sc_full, fade_full;
  logic signed [17:0]      shape_v;
  logic                    half;
  logic [31:0]             lfsr_1, lfsr_2, lfsr_3;
  logic [25:0]             fade_sum;
  logic signed [26:0]      freq;
  logic signed [25:0]      offs_v;
  logic                    slot_free;

  // shaped phase in Q0.24
  assign off_w  = ({32'b0, cfg_i.phase_offset} << Up) >> Dn;
  assign off_pb = off_w[PHASE_BITS-1:0];
  assign ph_pb  = phase_acc_q + off_pb;
  assign ph_w   = ({{(56 - PHASE_BITS){1'b0}}, ph_pb} << Dn) >> Up;
  assign ph24   = ph_w[23:0];
  assign half   = (ph24 > 24'h800000);

  // shape terms
  assign ph4    = $signed({2'b00, ph24, 2'b00});
  assign ramp_t = $signed({3'b000, ph24, 1'b0}) - 28'sd16777216;
  assign saw_t  = 28'sd16777216 - $signed({3'b000, ph24, 1'b0});
  assign sine_x = $signed({1'b0, ph24, 1'b0}) - 26'sd16777216;
  assign sine_ax = sine_x[25] ? -sine_x : sine_x;
  assign sine_b = 26'sd16777216 - sine_ax;
  assign sine_neg = -mul_q;

  always_comb begin
    if (ph24 < 24'h400000) begin
      tri_t = ph4;
    end else if (ph24 > 24'hC00000) begin
      tri_t = ph4 - 28'sd67108864;
    end else begin
      tri_t = 28'sd33554432 - ph4;
    end
  end

  // shape value per wave
  always_comb begin
    unique case (cfg_i.wave_select)
      WaveTri:    shape_v = tri_t[25:8];
      WaveSine:   shape_v = sine_neg[47:30];
      WavePulse3: shape_v = (ph24 < 24'hC00000) ? OneQ16 : '0;
      WaveSquare: shape_v = (ph24 < 24'h800000) ? OneQ16 : '0;
      WavePulse1: shape_v = (ph24 < 24'h400000) ? OneQ16 : '0;
      WavePulse8: shape_v = (ph24 < 24'h200000) ? OneQ16 : '0;
      WaveRamp:   shape_v = ramp_t[25:8];
      WaveSaw:    shape_v = saw_t[25:8];
      WaveHold:   shape_v = hold_value_q;
      default:    shape_v = '0;
    endcase
  end

  // xorshift step
  assign lfsr_1 = lfsr_q ^ (lfsr_q << 13);
  assign lfsr_2 = lfsr_1 ^ (lfsr_1 >> 17);
  assign lfsr_3 = lfsr_2 ^ (lfsr_2 << 5);

  // gain, fade and phase increment terms
  assign sc_full   = mul_q >>> 16;
  assign offs_v    = (cfg_i.wave_select > WaveHold) ? '0
                   : 26'(cfg_i.out_offset) + sc_full[25:0];
  assign fade_full = mul_q >>> 24;
  assign fade_sum  = {1'b0, fade_pos_q} + {2'b00, cfg_i.fade_step};
  assign freq      = $signed({3'b000, cfg_i.base_freq}) + 27'(fmod_q);
  assign phase_up  = mul_q[44-PHASE_BITS +: PHASE_BITS];

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      SSine: begin
        mul_a = 34'(sine_x);
        mul_b = 27'(sine_b);
      end
      SScale: begin
        mul_a = 34'(cfg_i.out_scale);
        mul_b = 27'(shape_q);
      end
      SFade: begin
        mul_a = 34'(val_q);
        mul_b = $signed({2'b00, fade_pos_q});
      end
      SFade2: begin
        mul_a = $signed({2'b00, cfg_i.rate_ratio});
        mul_b = freq;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  assign slot_free = !res_valid_q || pop_i;
  assign q_rd_o    = (state_q == SIdle) && q_valid_i;
  assign empty_o   = !res_valid_q;
  assign res_o     = res_q;

  // sequencer with voice state and result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      phase_acc_q  <= '0;
      fade_pos_q   <= OneQ24;
      hold_value_q <= '0;
      hold_half_q  <= 1'b0;
      lfsr_q       <= LfsrSeed;
      shape_q      <= '0;
      val_q        <= '0;
      dly_q        <= 1'b0;
      fmod_q       <= '0;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      // a popped beat frees the slot unless a new beat fills it
      if (pop_i && res_valid_q && (state_q != SEmit)) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (q_valid_i) begin
            fmod_q <= q_op_i.freq_mod;
            dly_q  <= q_op_i.delay_flag;
            val_q  <= '0;
            unique case (q_op_i.kind)
              OpStart: begin
                phase_acc_q  <= '0;
                hold_value_q <= '0;
                hold_half_q  <= 1'b0;
                fade_pos_q   <= (cfg_i.fade_step != '0) ? '0 : OneQ24;
                state_q      <= SEmit;
              end
              OpDelay: state_q <= SEmit;
              OpRun:   state_q <= SSine;
              default: state_q <= SEmit;
            endcase
          end
        end
        SSine: state_q <= SShape;
        SShape: begin
          shape_q <= shape_v;
          // sample-and-hold on a half-cycle crossing
          if (cfg_i.wave_select == WaveHold) begin
            hold_half_q <= half;
            if (half != hold_half_q) begin
              lfsr_q       <= lfsr_3;
              hold_value_q <= $signed({1'b0, lfsr_3[31:15]}) - OneQ16;
            end
          end
          state_q <= SScale;
        end
        SScale: state_q <= SOffs;
        SOffs: begin
          val_q   <= offs_v;
          state_q <= SFade;
        end
        SFade: state_q <= SFade2;
        SFade2: begin
          if (fade_pos_q < OneQ24) begin
            val_q      <= fade_full[25:0];
            fade_pos_q <= (fade_sum > {1'b0, OneQ24}) ? OneQ24 : fade_sum[24:0];
          end
          state_q <= SPhase;
        end
        SPhase: begin
          phase_acc_q <= phase_acc_q + phase_up;
          state_q     <= SEmit;
        end
        SEmit: begin
          if (slot_free) begin
            res_valid_q    <= 1'b1;
            res_q.in_delay <= dly_q;
            if (val_q > SatMax) begin
              res_q.lfo_value <= SatMax[23:0];
            end else if (val_q < SatMin) begin
              res_q.lfo_value <= SatMin[23:0];
            end else begin
              res_q.lfo_value <= val_q[23:0];
            end
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

/* hdl/lfo_waveform_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_waveform_generator
// Low-frequency oscillator voice with start delay, fade-in and random hold.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats are pushed with push while full is low. A tick (cmd 0)
//   carries a frequency modulation; a start (cmd 1) restarts the voice and
//   loads the start delay. Each input beat gives exactly one result beat,
//   read with pop while empty is low, oldest first.
//   Configuration is written through cfg_valid_i/cfg_ready_o (always ready)
//   with a register index and data; it must be written by the user only
//   while the voice is idle, which the block does not enforce. A running
//   tick passes the sine, shape, scale, offset, fade, phase and emit states
//   (one shared multiplier pass each for sine, gain, fade and phase step);
//   start and delay beats go straight to emit. One item executes at a time.
//   A two-entry queue between the input classifier and the execution unit
//   keeps accepting beats while a result waits in the output slot.
//   Reset clears the queue, the delay count, the phase and the hold state,
//   sets the fade gain to one and reseeds the noise register.
//   When the receiver stalls, the finished result holds, the execution unit
//   waits, and once the queue fills full is raised.
// ----------------------------------------------------------------------------
module lfo_waveform_generator
  import lfo_pkg::*;
#(
  parameter int PHASE_BITS = PhaseBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t cfg_q;
  logic q_wr, q_full, q_rd, q_valid;
  op_t  q_wr_op, q_rd_op;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_freq    <= '0;
      cfg_q.rate_ratio   <= '0;
      cfg_q.phase_offset <= '0;
      cfg_q.wave_select  <= WaveTri;
      cfg_q.out_scale    <= ScaleRst;
      cfg_q.out_offset   <= '0;
      cfg_q.delay_frames <= '0;
      cfg_q.fade_step    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBaseFreq:    cfg_q.base_freq    <= cfg_data_i[23:0];
        RegRateRatio:   cfg_q.rate_ratio   <= cfg_data_i;
        RegPhaseOffset: cfg_q.phase_offset <= cfg_data_i[23:0];
        RegWaveSelect:  cfg_q.wave_select  <= cfg_data_i[3:0];
        RegOutScale:    cfg_q.out_scale    <= cfg_data_i[23:0];
        RegOutOffset:   cfg_q.out_offset   <= cfg_data_i[23:0];
        RegDelayFrames: cfg_q.delay_frames <= cfg_data_i[22:0];
        RegFadeStep:    cfg_q.fade_step    <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // input classifier
  lfo_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .push_i   (push),
    .item_i   (in_item_i),
    .q_full_i (q_full),
    .full_o   (full),
    .q_wr_o   (q_wr),
    .q_op_o   (q_wr_op)
  );

  // operation queue
  lfo_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wr_op_i (q_wr_op),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rd_op_o (q_rd_op),
    .valid_o (q_valid)
  );

  // execution unit
  lfo_back #(
    .PHASE_BITS (PHASE_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_op_i    (q_rd_op),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (out_item_o)
  );

endmodule

/* verif/tb_lfo_waveform_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lfo_waveform_generator
// Self-checking bench for the oscillator voice: a cycle-free predictor keeps
// its own copy of phase, delay, fade and hold state, expects one result per
// accepted input beat and compares every popped beat field by field. Directed
// beats sweep all shapes and the extremes, then randomized register settings
// drive mostly well-formed start/tick sequences with random idling on both
// sides of the queue.
// ----------------------------------------------------------------------------
module tb_lfo_waveform_generator;
  import lfo_pkg::*;

  localparam int     ItemTarget = 1900;
  localparam int     Settle     = 12;
  localparam int     EndSettle  = 24;
  localparam longint TimeoutNs  = 5000000;

  // fixed-point reference points of one cycle, Q0.24
  localparam longint QOne     = 16777216;
  localparam longint QHalf    = 8388608;
  localparam longint QQuarter = 4194304;
  localparam longint QEighth  = 2097152;

  // predictor and store of expected output beats
  class lfo_checker;
    cfg_t               regs;
    logic [23:0]        phase_acc;
    logic [23:0]        delay_left;
    logic [24:0]        fade_pos;
    logic signed [17:0] hold_value;
    logic               hold_half;
    logic [31:0]        noise_lfsr;
    out_item_t          expected_samples[$];
    int                 errors;
    int                 n_checked;
    int                 n_start;
    int                 n_delay;
    int                 n_run;

    function new();
      regs.base_freq    = '0;
      regs.rate_ratio   = '0;
      regs.phase_offset = '0;
      regs.wave_select  = WaveTri;
      regs.out_scale    = ScaleRst;
      regs.out_offset   = '0;
      regs.delay_frames = '0;
      regs.fade_step    = '0;
      phase_acc  = '0;
      delay_left = '0;
      fade_pos   = OneQ24;
      hold_value = '0;
      hold_half  = 1'b0;
      noise_lfsr = LfsrSeed;
      errors     = 0;
      n_checked  = 0;
      n_start    = 0;
      n_delay    = 0;
      n_run      = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] word);
      case (idx)
        RegBaseFreq:    regs.base_freq    = word[23:0];
        RegRateRatio:   regs.rate_ratio   = word;
        RegPhaseOffset: regs.phase_offset = word[23:0];
        RegWaveSelect:  regs.wave_select  = word[3:0];
        RegOutScale:    regs.out_scale    = word[23:0];
        RegOutOffset:   regs.out_offset   = word[23:0];
        RegDelayFrames: regs.delay_frames = word[22:0];
        RegFadeStep:    regs.fade_step    = word[23:0];
        default: ;
      endcase
    endfunction

    // shape value in Q1.16, floored
    function longint shape_value(logic [3:0] wave, longint ph);
      longint t;
      longint x;
      longint ax;
      case (wave)
        WaveTri: begin
          if (ph < QQuarter) t = 4 * ph;
          else if (ph > 3 * QQuarter) t = 4 * ph - 4 * QOne;
          else t = 2 * QOne - 4 * ph;
          return t >>> 8;
        end
        WaveSine: begin
          x  = 2 * ph - QOne;
          ax = (x < 0) ? -x : x;
          return (-(x * (QOne - ax))) >>> 30;
        end
        WavePulse3: return (ph < 3 * QQuarter) ? 65536 : 0;
        WaveSquare: return (ph < QHalf) ? 65536 : 0;
        WavePulse1: return (ph < QQuarter) ? 65536 : 0;
        WavePulse8: return (ph < QEighth) ? 65536 : 0;
        WaveRamp:   return (2 * ph - QOne) >>> 8;
        WaveSaw:    return (QOne - 2 * ph) >>> 8;
        default:    return 0;
      endcase
    endfunction

    // advance the voice by one accepted input beat
    function void note_beat(in_item_t beat);
      out_item_t   e;
      logic [23:0] ph_word;
      logic [23:0] step;
      longint      ph;
      longint      v;
      longint      freq;
      longint      prod;
      logic        half;
      if (beat.cmd == CmdStart) begin
        phase_acc  = '0;
        hold_value = '0;
        hold_half  = 1'b0;
        delay_left = {1'b0, beat.trigger_delay} + {1'b0, regs.delay_frames};
        fade_pos   = (regs.fade_step != 0) ? 25'd0 : OneQ24;
        e.lfo_value = '0;
        e.in_delay  = (delay_left != 0);
        n_start++;
      end else if (delay_left != 0) begin
        delay_left--;
        e.lfo_value = '0;
        e.in_delay  = 1'b1;
        n_delay++;
      end else begin
        ph_word = phase_acc + regs.phase_offset;
        ph      = longint'(ph_word);
        if (regs.wave_select == WaveHold) begin
          v    = longint'(hold_value);
          half = (ph > QHalf);
          if (half != hold_half) begin
            noise_lfsr = noise_lfsr ^ (noise_lfsr << 13);
            noise_lfsr = noise_lfsr ^ (noise_lfsr >> 17);
            noise_lfsr = noise_lfsr ^ (noise_lfsr << 5);
            hold_value = 18'(longint'(noise_lfsr >> 15) - 65536);
          end
          hold_half = half;
        end else begin
          v = shape_value(regs.wave_select, ph);
        end
        if (regs.wave_select <= WaveHold)
          v = longint'(regs.out_offset) + ((longint'(regs.out_scale) * v) >>> 16);
        else
          v = 0;
        // fade-in gain, floored
        if (fade_pos < OneQ24) begin
          v = (v * longint'(fade_pos)) >>> 24;
          fade_pos = fade_pos + regs.fade_step;
          if (fade_pos > OneQ24) fade_pos = OneQ24;
        end
        if (v > longint'(SatMax)) v = longint'(SatMax);
        if (v < longint'(SatMin)) v = longint'(SatMin);
        // phase step: Q12.44 product floored to Q0.24
        freq      = longint'(regs.base_freq) + longint'(beat.freq_mod);
        prod      = longint'(regs.rate_ratio) * freq;
        step      = prod[43:20];
        phase_acc = phase_acc + step;
        e.lfo_value = v[23:0];
        e.in_delay  = 1'b0;
        n_run++;
      end
      expected_samples.push_back(e);
    endfunction

    function void check_beat(out_item_t got);
      out_item_t e;
      if (expected_samples.size() == 0) begin
        $error("result beat with no expectation: lfo_value %0d in_delay %0d",
               got.lfo_value, got.in_delay);
        errors++;
        return;
      end
      e = expected_samples.pop_front();
      n_checked++;
      if (got.lfo_value !== e.lfo_value) begin
        $error("lfo_value mismatch: expected %0d, actual %0d", e.lfo_value, got.lfo_value);
        errors++;
      end
      if (got.in_delay !== e.in_delay) begin
        $error("in_delay mismatch: expected %0d, actual %0d", e.in_delay, got.in_delay);
        errors++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  in_item_t    in_item_i   = '0;
  logic        empty;
  logic        pop         = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;

  logic       no_idle    = 1'b0;
  int         n_items    = 0;
  int         n_settings = 0;
  lfo_checker sb;

  lfo_waveform_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic in_item_t mk_beat(logic cmd, logic [23:0] fm, logic [22:0] td);
    in_item_t b;
    b.cmd           = cmd;
    b.freq_mod      = fm;
    b.trigger_delay = td;
    return b;
  endfunction

  function automatic cfg_t mk_cfg(logic [23:0] base, logic [31:0] rate, logic [23:0] offs,
                                  logic [3:0] wave, logic [23:0] scale, logic [23:0] level,
                                  logic [22:0] dly, logic [23:0] fade);
    cfg_t c;
    c.base_freq    = base;
    c.rate_ratio   = rate;
    c.phase_offset = offs;
    c.wave_select  = wave;
    c.out_scale    = scale;
    c.out_offset   = level;
    c.delay_frames = dly;
    c.fade_step    = fade;
    return c;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    case ($urandom_range(0, 5))
      0:       c.base_freq = '0;
      1:       c.base_freq = '1;
      default: c.base_freq = 24'($urandom) >> $urandom_range(0, 23);
    endcase
    case ($urandom_range(0, 5))
      0:       c.rate_ratio = '0;
      1:       c.rate_ratio = '1;
      default: c.rate_ratio = $urandom >> $urandom_range(0, 31);
    endcase
    case ($urandom_range(0, 4))
      0:       c.phase_offset = '0;
      1:       c.phase_offset = '1;
      default: c.phase_offset = 24'($urandom);
    endcase
    if ($urandom_range(0, 7) == 0) c.wave_select = 4'($urandom_range(9, 15));
    else c.wave_select = 4'($urandom_range(WaveTri, WaveHold));
    case ($urandom_range(0, 5))
      0:       c.out_scale = 24'sh800000;
      1:       c.out_scale = 24'sh7FFFFF;
      2:       c.out_scale = ScaleRst;
      default: c.out_scale = $signed(24'($urandom)) >>> $urandom_range(0, 12);
    endcase
    case ($urandom_range(0, 5))
      0:       c.out_offset = 24'sh800000;
      1:       c.out_offset = 24'sh7FFFFF;
      2:       c.out_offset = '0;
      default: c.out_offset = $signed(24'($urandom)) >>> $urandom_range(0, 12);
    endcase
    if ($urandom_range(0, 15) == 0) c.delay_frames = 23'($urandom);
    else c.delay_frames = 23'($urandom_range(0, 6));
    case ($urandom_range(0, 4))
      0, 1: c.fade_step = '0;
      2:    c.fade_step = 24'($urandom_range(1, 1 << 18));
      3:    c.fade_step = '1;
      default: c.fade_step = 24'($urandom);
    endcase
    return c;
  endfunction

  // push one input beat, idling at random before it
  task automatic send_beat(input in_item_t beat);
    while (!no_idle && $urandom_range(0, 99) < 17) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= beat;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_beat(beat);
    n_items++;
  endtask

  // hold off the sender until every expected result has been popped
  task automatic drain_voice();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  // write all eight registers while the voice is idle
  task automatic program_voice(input cfg_t c);
    logic [31:0] word;
    drain_voice();
    for (int i = 0; i < 8; i++) begin
      // unused upper data bits stay random
      word = $urandom;
      case (3'(i))
        RegBaseFreq:    word[23:0] = c.base_freq;
        RegRateRatio:   word       = c.rate_ratio;
        RegPhaseOffset: word[23:0] = c.phase_offset;
        RegWaveSelect:  word[3:0]  = c.wave_select;
        RegOutScale:    word[23:0] = c.out_scale;
        RegOutOffset:   word[23:0] = c.out_offset;
        RegDelayFrames: word[22:0] = c.delay_frames;
        default:        word[23:0] = c.fade_step;
      endcase
      cfg_index_i <= 3'(i);
      cfg_data_i  <= word;
      cfg_valid_i <= 1'b1;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.write_reg(3'(i), word);
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // result side: pop with random stalls
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_beat(out_item_o);
      pop <= no_idle || ($urandom_range(0, 99) >= 17);
    end
  end

  // run limit
  initial begin
    #(TimeoutNs);
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin
    int          n_phase;
    int          n_beats;
    logic [23:0] fm;
    logic [22:0] td;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset defaults: zero rate keeps the phase at zero
    send_beat(mk_beat(CmdTick, 24'h7FFFFF, 23'h7FFFFF));
    send_beat(mk_beat(CmdTick, 24'h800000, 23'h000000));

    // shape sweep at three eighths of a cycle per tick
    for (int w = WaveTri; w <= WaveHold; w++) begin
      program_voice(mk_cfg(24'd6144, 32'h4000_0000, '0, 4'(w), ScaleRst, '0, '0, '0));
      send_beat(mk_beat(CmdTick, '0, '0));
      send_beat(mk_beat(CmdTick, '0, '0));
    end
    // unknown shape gives zero while phase runs
    program_voice(mk_cfg(24'd6144, 32'h4000_0000, '0, 4'd12, ScaleRst, '0, '0, '0));
    send_beat(mk_beat(CmdTick, '0, '0));

    // longest start delay, then a tick inside it
    program_voice(mk_cfg('1, '1, '1, WaveSine, 24'sh800000, 24'sh7FFFFF, '1, '1));
    send_beat(mk_beat(CmdStart, '0, '1));
    send_beat(mk_beat(CmdTick, 24'h7FFFFF, '0));

    // fade from zero and saturation at the low end
    program_voice(mk_cfg('1, '1, '0, WaveSquare, 24'sh800000, 24'sh800000, '0, '1));
    send_beat(mk_beat(CmdStart, '0, '0));
    send_beat(mk_beat(CmdTick, '0, '0));
    send_beat(mk_beat(CmdTick, 24'h800000, '0));
    send_beat(mk_beat(CmdTick, '0, '0));

    // randomized settings, each mostly a start followed by ticks
    n_phase = 0;
    while (n_items < ItemTarget) begin
      no_idle = (n_phase >= 10) && (n_phase < 14);
      program_voice(rand_cfg());
      if ($urandom_range(0, 3) != 0)
        send_beat(mk_beat(CmdStart, 24'($urandom), 23'($urandom_range(0, 4))));
      n_beats = $urandom_range(35, 60);
      for (int k = 0; k < n_beats; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          if ($urandom_range(0, 9) == 0) td = 23'($urandom);
          else td = 23'($urandom_range(0, 4));
          send_beat(mk_beat(CmdStart, 24'($urandom), td));
        end else begin
          if ($urandom_range(0, 1) != 0) fm = 24'($urandom);
          else fm = 24'($urandom_range(0, 400)) - 24'd200;
          send_beat(mk_beat(CmdTick, fm, 23'($urandom)));
        end
      end
      n_phase++;
    end
    no_idle = 1'b0;

    // wait out the remaining results
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (EndSettle) @(posedge clk_i);

    $display("covered %0d input beats over %0d register settings: %0d starts, %0d delay ticks,",
             n_items, n_settings, sb.n_start, sb.n_delay);
    $display("%0d running ticks; %0d results checked, %0d mismatches",
             sb.n_run, sb.n_checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
